FILE: rtl/core/gtf_pkg.sv
// Package for the gammatone channel filter: word types, register indexes,
// operation codes and the sequencer step table.
// No dependencies.
package gtf_pkg;

  localparam int HISTORY_WIDTH_DEF = 56;
  localparam int CLIP_THRESHOLD_DEF = 1;
  localparam int ACC_W = 130;
  localparam int BOP_W = 64;
  localparam int RAD_W = 128;
  localparam int ROOT_W = 64;
  localparam int STEP_W = 6;
  localparam int NUM_STEPS = 34;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE_ONE   = 3'd0,
    CFG_POLE_TWO   = 3'd1,
    CFG_POLE_THREE = 3'd2,
    CFG_POLE_FOUR  = 3'd3,
    CFG_ZERO       = 3'd4,
    CFG_STEP_COS   = 3'd5,
    CFG_STEP_SIN   = 3'd6,
    CFG_GAIN       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               mode;
    logic               restart;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] membrane;
    logic [30:0]        envelope;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_MAC, OP_SQRT, OP_FIN_POLE, OP_FIN_ZERO, OP_FIN_T,
    OP_FIN_MEMB, OP_FIN_ENV, OP_FIN_COS, OP_FIN_SIN
  } op_e;

  typedef enum logic [3:0] {
    A_XS, A_H0, A_H1, A_H2, A_H3, A_UR, A_UI, A_T, A_M, A_COS, A_SIN
  } asel_e;

  typedef enum logic [3:0] {
    B_COS, B_SIN, B_C1, B_C2, B_C3, B_C4, B_ZC, B_SC, B_SS, B_GAIN, B_UR, B_UI
  } bsel_e;

  typedef struct packed {
    op_e   op;
    asel_e a;
    bsel_e b;
    logic  imag;
    logic  neg;
  } step_t;

  typedef struct packed {
    logic              accept;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic out_free;
  } stat_t;

  // One entry per sequencer step; every step either starts a multiply
  // accumulate, starts the square root, or finishes a value from the
  // accumulator.
  function automatic step_t step_info(input logic [STEP_W-1:0] idx);
    step_t s;
    s = '{OP_FIN_SIN, A_XS, B_COS, 1'b1, 1'b0};
    case (idx)
      6'd0:  s = '{OP_MAC, A_XS, B_COS, 1'b0, 1'b0};
      6'd1:  s = '{OP_MAC, A_H0, B_C1, 1'b0, 1'b0};
      6'd2:  s = '{OP_MAC, A_H1, B_C2, 1'b0, 1'b0};
      6'd3:  s = '{OP_MAC, A_H2, B_C3, 1'b0, 1'b0};
      6'd4:  s = '{OP_MAC, A_H3, B_C4, 1'b0, 1'b0};
      6'd5:  s = '{OP_FIN_POLE, A_XS, B_COS, 1'b0, 1'b0};
      6'd6:  s = '{OP_MAC, A_H0, B_C1, 1'b0, 1'b0};
      6'd7:  s = '{OP_MAC, A_H1, B_ZC, 1'b0, 1'b0};
      6'd8:  s = '{OP_FIN_ZERO, A_XS, B_COS, 1'b0, 1'b0};
      6'd9:  s = '{OP_MAC, A_XS, B_SIN, 1'b1, 1'b0};
      6'd10: s = '{OP_MAC, A_H0, B_C1, 1'b1, 1'b0};
      6'd11: s = '{OP_MAC, A_H1, B_C2, 1'b1, 1'b0};
      6'd12: s = '{OP_MAC, A_H2, B_C3, 1'b1, 1'b0};
      6'd13: s = '{OP_MAC, A_H3, B_C4, 1'b1, 1'b0};
      6'd14: s = '{OP_FIN_POLE, A_XS, B_COS, 1'b1, 1'b0};
      6'd15: s = '{OP_MAC, A_H0, B_C1, 1'b1, 1'b0};
      6'd16: s = '{OP_MAC, A_H1, B_ZC, 1'b1, 1'b0};
      6'd17: s = '{OP_FIN_ZERO, A_XS, B_COS, 1'b1, 1'b0};
      6'd18: s = '{OP_MAC, A_UR, B_COS, 1'b0, 1'b0};
      6'd19: s = '{OP_MAC, A_UI, B_SIN, 1'b0, 1'b0};
      6'd20: s = '{OP_FIN_T, A_XS, B_COS, 1'b0, 1'b0};
      6'd21: s = '{OP_MAC, A_T, B_GAIN, 1'b0, 1'b0};
      6'd22: s = '{OP_FIN_MEMB, A_XS, B_COS, 1'b0, 1'b0};
      6'd23: s = '{OP_MAC, A_UR, B_UR, 1'b0, 1'b0};
      6'd24: s = '{OP_MAC, A_UI, B_UI, 1'b0, 1'b0};
      6'd25: s = '{OP_SQRT, A_XS, B_COS, 1'b0, 1'b0};
      6'd26: s = '{OP_MAC, A_M, B_GAIN, 1'b0, 1'b0};
      6'd27: s = '{OP_FIN_ENV, A_XS, B_COS, 1'b0, 1'b0};
      6'd28: s = '{OP_MAC, A_COS, B_SC, 1'b0, 1'b0};
      6'd29: s = '{OP_MAC, A_SIN, B_SS, 1'b0, 1'b0};
      6'd30: s = '{OP_FIN_COS, A_XS, B_COS, 1'b0, 1'b0};
      6'd31: s = '{OP_MAC, A_SIN, B_SC, 1'b0, 1'b0};
      6'd32: s = '{OP_MAC, A_COS, B_SS, 1'b0, 1'b1};
      default: s = '{OP_FIN_SIN, A_XS, B_COS, 1'b1, 1'b0};
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/gtf_sqrt.sv
// Digit-recurrence integer square root, two radicand bits per cycle.
// Depends on gtf_pkg.
module gtf_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gtf_pkg::RAD_W-1:0] rad_i,
  output logic                      done_o,
  output logic [gtf_pkg::ROOT_W-1:0] root_o
);
  import gtf_pkg::*;

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q, rem_sh, trial, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
    trial  = {2'b00, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/core/gtf_datapath.sv
// Datapath of the gammatone channel: configuration registers, filter state,
// bit-serial multiply accumulate, result finishing and output register.
// Depends on gtf_pkg and gtf_sqrt.
module gtf_datapath #(
  parameter int HISTORY_WIDTH = gtf_pkg::HISTORY_WIDTH_DEF,
  parameter int CLIP_THRESHOLD_LSB = gtf_pkg::CLIP_THRESHOLD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gtf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gtf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  gtf_pkg::in_word_t              in_word_i,
  input  gtf_pkg::cmd_t                  cmd_i,
  output gtf_pkg::stat_t                 stat_o,
  output gtf_pkg::out_word_t             out_word_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i
);
  import gtf_pkg::*;

  localparam int HW = HISTORY_WIDTH;
  localparam int CNT_W = $clog2(BOP_W + 1);
  localparam logic signed [HW-1:0] CLIP_POS = HW'(CLIP_THRESHOLD_LSB);
  localparam logic signed [HW-1:0] CLIP_NEG = -CLIP_POS;
  localparam logic signed [HW-1:0] HW_MAX = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] HW_MIN = {1'b1, {(HW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF27 = ACC_W'(1) << 26;
  localparam logic signed [ACC_W-1:0] HALF30 = ACC_W'(1) << 29;
  localparam logic signed [ACC_W-1:0] HALF32 = ACC_W'(1) << 31;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:31]) | ~(|v[ACC_W-1:31]);
    if (fits) return v[31:0];
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Configuration.
  logic signed [31:0] c1_q, c2_q, c3_q, c4_q, zc_q, sc_q, ss_q;
  logic [30:0]        gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0; zc_q <= '0;
      sc_q <= ONE_Q30; ss_q <= '0; gain_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POLE_ONE:   c1_q <= cfg_data_i;
        CFG_POLE_TWO:   c2_q <= cfg_data_i;
        CFG_POLE_THREE: c3_q <= cfg_data_i;
        CFG_POLE_FOUR:  c4_q <= cfg_data_i;
        CFG_ZERO:       zc_q <= cfg_data_i;
        CFG_STEP_COS:   sc_q <= cfg_data_i;
        CFG_STEP_SIN:   ss_q <= cfg_data_i;
        CFG_GAIN:       gain_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Current step and working values.
  step_t st;
  assign st = step_info(cmd_i.step);

  logic signed [HW-1:0] hre_q [4];
  logic signed [HW-1:0] him_q [4];
  logic signed [31:0]   cos_q, sin_q, nc_q, memb_q;
  logic signed [15:0]   x_q;
  logic                 pad_q;
  logic signed [HW-1:0] pr_q, pi_q, ur_q, ui_q;
  logic signed [63:0]   t_q;
  logic [ROOT_W-1:0]    m_q, root;
  logic [30:0]          env_q;

  // Accumulator and bit-serial multiplier.
  logic signed [ACC_W-1:0] acc_q, a_q, a_sel;
  logic signed [BOP_W-1:0] b_q, b_sel;
  logic [CNT_W-1:0]        cnt_q, nb_q, nb_sel;
  logic                    mac_busy_q, neg_q, mac_last, mac_sub;
  logic                    sqrt_start, sqrt_done;

  always_comb begin
    case (st.a)
      A_XS:  a_sel = ACC_W'(x_q) <<< 13;
      A_H0:  a_sel = ACC_W'(st.imag ? him_q[0] : hre_q[0]);
      A_H1:  a_sel = ACC_W'(st.imag ? him_q[1] : hre_q[1]);
      A_H2:  a_sel = ACC_W'(st.imag ? him_q[2] : hre_q[2]);
      A_H3:  a_sel = ACC_W'(st.imag ? him_q[3] : hre_q[3]);
      A_UR:  a_sel = ACC_W'(ur_q);
      A_UI:  a_sel = ACC_W'(ui_q);
      A_T:   a_sel = ACC_W'(t_q);
      A_M:   a_sel = ACC_W'(m_q);
      A_COS: a_sel = ACC_W'(cos_q);
      A_SIN: a_sel = ACC_W'(sin_q);
      default: a_sel = '0;
    endcase
    nb_sel = CNT_W'(32);
    case (st.b)
      B_COS:  b_sel = BOP_W'(cos_q);
      B_SIN:  b_sel = BOP_W'(sin_q);
      B_C1:   b_sel = BOP_W'(c1_q);
      B_C2:   b_sel = BOP_W'(c2_q);
      B_C3:   b_sel = BOP_W'(c3_q);
      B_C4:   b_sel = BOP_W'(c4_q);
      B_ZC:   b_sel = BOP_W'(zc_q);
      B_SC:   b_sel = BOP_W'(sc_q);
      B_SS:   b_sel = BOP_W'(ss_q);
      B_GAIN: b_sel = BOP_W'(gain_q);
      B_UR: begin
        b_sel  = BOP_W'(ur_q);
        nb_sel = CNT_W'(HW);
      end
      B_UI: begin
        b_sel  = BOP_W'(ui_q);
        nb_sel = CNT_W'(HW);
      end
      default: b_sel = '0;
    endcase
  end

  // The multiplier's top bit carries negative weight.
  assign mac_last = (cnt_q == CNT_W'(nb_q - 1'b1));
  assign mac_sub  = mac_last ^ neg_q;

  // Rounded views of the accumulator.
  logic signed [ACC_W-1:0] r27, r30, r32;
  logic signed [HW-1:0]    r27_sat, p_clip;
  logic signed [63:0]      r30_sat64;

  always_comb begin
    r27 = (acc_q + HALF27) >>> 27;
    r30 = (acc_q + HALF30) >>> 30;
    r32 = (acc_q + HALF32) >>> 32;
    if ((&r27[ACC_W-1:HW-1]) | ~(|r27[ACC_W-1:HW-1])) r27_sat = r27[HW-1:0];
    else r27_sat = r27[ACC_W-1] ? HW_MIN : HW_MAX;
    if ((&r30[ACC_W-1:63]) | ~(|r30[ACC_W-1:63])) r30_sat64 = r30[63:0];
    else r30_sat64 = r30[ACC_W-1] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    p_clip = r27_sat;
    if (!pad_q && (r27_sat > CLIP_NEG) && (r27_sat < CLIP_POS)) p_clip = '0;
  end

  assign sqrt_start = cmd_i.issue && (st.op == OP_SQRT);

  gtf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_q[RAD_W-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_busy_q <= 1'b0;
    end else if (cmd_i.issue && (st.op == OP_MAC)) begin
      mac_busy_q <= 1'b1;
    end else if (mac_busy_q && mac_last) begin
      mac_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_q <= '0;
    end else if (cmd_i.issue) begin
      if (st.op == OP_MAC) begin
        a_q   <= a_sel;
        b_q   <= b_sel;
        nb_q  <= nb_sel;
        neg_q <= st.neg;
        cnt_q <= '0;
      end else if (st.op == OP_FIN_POLE) begin
        acc_q <= ACC_W'(p_clip) <<< 27;
      end else begin
        acc_q <= '0;
      end
    end else if (mac_busy_q) begin
      if (b_q[0]) acc_q <= mac_sub ? acc_q - a_q : acc_q + a_q;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >>> 1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Intermediate results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q   <= in_word_i.mode ? 16'sd0 : in_word_i.sample;
      pad_q <= in_word_i.mode;
    end
    if (sqrt_done) m_q <= root;
    if (cmd_i.issue) begin
      case (st.op)
        OP_FIN_POLE: begin
          if (st.imag) pi_q <= p_clip;
          else pr_q <= p_clip;
        end
        OP_FIN_ZERO: begin
          if (st.imag) ui_q <= r27_sat;
          else ur_q <= r27_sat;
        end
        OP_FIN_T:    t_q <= r30_sat64;
        OP_FIN_MEMB: memb_q <= pad_q ? 32'sd0 : sat32(r32);
        OP_FIN_ENV:  env_q <= (|r32[ACC_W-1:31]) ? 31'h7FFF_FFFF : r32[30:0];
        OP_FIN_COS:  nc_q <= sat32(r30);
        default: ;
      endcase
    end
  end

  // Filter history and carrier; restart clears the history and sets the carrier to one before the word runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hre_q[i] <= '0;
        him_q[i] <= '0;
      end
      cos_q <= ONE_Q30;
      sin_q <= '0;
    end else if (cmd_i.accept && in_word_i.restart) begin
      for (int i = 0; i < 4; i++) begin
        hre_q[i] <= '0;
        him_q[i] <= '0;
      end
      cos_q <= ONE_Q30;
      sin_q <= '0;
    end else if (cmd_i.issue && (st.op == OP_FIN_SIN)) begin
      hre_q[0] <= pr_q;
      him_q[0] <= pi_q;
      for (int i = 1; i < 4; i++) begin
        hre_q[i] <= hre_q[i-1];
        him_q[i] <= him_q[i-1];
      end
      if (!pad_q) begin
        cos_q <= nc_q;
        sin_q <= sat32(r30);
      end
    end
  end

  // Output register.
  logic      out_valid_q;
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= '{membrane: memb_q, envelope: env_q};
  end

  assign out_word_o      = out_q;
  assign out_valid_o     = out_valid_q;
  assign stat_o.unit_done = (mac_busy_q && mac_last) || sqrt_done;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

FILE: rtl/core/gtf_ctrl.sv
// Sequencer for the gammatone channel: walks the step table once per word.
// Depends on gtf_pkg.
module gtf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gtf_pkg::stat_t stat_i,
  output gtf_pkg::cmd_t  cmd_o
);
  import gtf_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  step_t             st;

  assign st = step_info(step_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '{accept: 1'b0, issue: 1'b0, step: step_q, load_out: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          step_d  = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if ((st.op == OP_MAC) || (st.op == OP_SQRT)) begin
          state_d = ST_WAIT;
        end else if (step_q == LAST_STEP) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (stat_i.unit_done) begin
          step_d  = step_q + 1'b1;
          state_d = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LAST_STEP) else $error("step index past end of table");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.unit_done |-> state_q == ST_WAIT) else $error("unit done outside wait");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == ST_IDLE) else $error("no return to idle after load");

  a_issue_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE && st.op == OP_MAC) |=> state_q == ST_WAIT)
    else $error("multiply issued without wait");

endmodule

FILE: rtl/core/gammatone_channel_filter.sv
// Top level of one fourth-order gammatone filter channel.
// Depends on gtf_pkg, gtf_ctrl, gtf_datapath and gtf_sqrt.
//
// Each accepted input word runs through a fixed sequence of steps on one
// bit-serial multiply accumulate unit and one two-bits-per-cycle square root
// unit, then lands in an output register. The 24 multiplies, 22 over 32-bit
// coefficients, gain and carrier and two over the history width (56 bits by
// default), run at one bit per cycle. Input is taken only while the sequencer
// is idle; a finished word may wait in the output register while the next
// input word is taken. Restart clears the filter history and sets the carrier
// to one before the word is processed. Pad words feed zero input, skip
// clipping and carrier rotation, and return a zero membrane value with the
// envelope computed as usual. Configuration registers are written through the
// write port; the user must write them only while the block is idle, as the
// block itself does not enforce this.
module gammatone_channel_filter #(
  parameter int HISTORY_WIDTH = gtf_pkg::HISTORY_WIDTH_DEF,
  parameter int CLIP_THRESHOLD_LSB = gtf_pkg::CLIP_THRESHOLD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gtf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gtf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gtf_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gtf_pkg::out_word_t             out_word_o
);
  import gtf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gtf_datapath #(
    .HISTORY_WIDTH      (HISTORY_WIDTH),
    .CLIP_THRESHOLD_LSB (CLIP_THRESHOLD_LSB)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
